@@ hdl/hcbd_pkg.sv @@
// Shared types, character codes and error codes for the chunked body decoder.
// No dependencies; imported by hcbd_core and http_chunked_body_decoder.
`default_nettype none

package hcbd_pkg;

  localparam int BUDGET_W = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_LARGE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
    logic       end_of_buffer;
  } hcbd_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       body_done;
    logic [1:0] error_code;
  } hcbd_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hcbd_hex_t;

  function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
    hcbd_hex_t h;
    h.is_hex = 1'b0;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ hdl/hcbd_core.sv @@
// Decoder state and per-byte next-state logic: size line parse, chunk checks,
// data pass-through and trailer check. Depends on hcbd_pkg.
`default_nettype none

module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire hcbd_item_t          item,
  input  wire logic                cfg_wr_en,
  input  wire logic [BUDGET_W-1:0] cfg_wr_data,
  output hcbd_result_t             result
);

  localparam int CMP_W = (COUNT_WIDTH > BUDGET_W) ? COUNT_WIDTH : BUDGET_W;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_SKIP,
    PH_DATA,
    PH_TCR,
    PH_TLF
  } phase_t;

  logic [BUDGET_W-1:0]    max_body_bytes_r;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] size_accum_r, size_accum_nxt;
  logic [1:0]             line_length_r, line_length_nxt;
  logic                   first_char_zero_r, first_char_zero_nxt;
  logic                   hex_stopped_r, hex_stopped_nxt;
  logic                   hex_overflow_r, hex_overflow_nxt;
  logic [BUDGET_W-1:0]    budget_left_r, budget_left_nxt;
  logic [COUNT_WIDTH-1:0] data_left_r, data_left_nxt;
  logic                   done_flag_r, done_flag_nxt;
  logic [1:0]             error_state_r, error_state_nxt;

  hcbd_hex_t              hex;
  logic [CMP_W-1:0]       size_ext;
  logic [CMP_W-1:0]       budget_ext;
  logic [CMP_W-1:0]       budget_diff;
  logic [COUNT_WIDTH-1:0] data_dec;
  logic                   valid;

  assign hex         = hex_decode(item.data_byte);
  assign size_ext    = CMP_W'(size_accum_r);
  assign budget_ext  = CMP_W'(budget_left_r);
  assign budget_diff = budget_ext - size_ext;
  assign data_dec    = data_left_r - COUNT_WIDTH'(1);

  always_comb begin
    phase_nxt           = phase_r;
    size_accum_nxt      = size_accum_r;
    line_length_nxt     = line_length_r;
    first_char_zero_nxt = first_char_zero_r;
    hex_stopped_nxt     = hex_stopped_r;
    hex_overflow_nxt    = hex_overflow_r;
    budget_left_nxt     = budget_left_r;
    data_left_nxt       = data_left_r;
    done_flag_nxt       = done_flag_r;
    error_state_nxt     = error_state_r;
    valid               = 1'b0;

    if (item.start_of_body) begin
      phase_nxt           = PH_SIZE;
      size_accum_nxt      = '0;
      line_length_nxt     = 2'd0;
      first_char_zero_nxt = 1'b0;
      hex_stopped_nxt     = 1'b0;
      hex_overflow_nxt    = 1'b0;
      budget_left_nxt     = max_body_bytes_r;
      data_left_nxt       = '0;
      done_flag_nxt       = 1'b0;
      error_state_nxt     = ERR_NONE;
    end

    if (!done_flag_nxt && error_state_nxt == ERR_NONE) begin
      unique case (phase_nxt)
        PH_SIZE: begin
          if (item.data_byte == CH_CR) begin
            if (line_length_nxt == 2'd1 && first_char_zero_nxt) begin
              done_flag_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            if (line_length_nxt == 2'd0 && item.data_byte == CH_ZERO) begin
              first_char_zero_nxt = 1'b1;
            end
            if (line_length_nxt != 2'd2) begin
              line_length_nxt = line_length_nxt + 2'd1;
            end
            if (!hex.is_hex) begin
              hex_stopped_nxt = 1'b1;
            end else if (!hex_stopped_nxt && !hex_overflow_nxt) begin
              if (size_accum_nxt[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                hex_overflow_nxt = 1'b1;
              end else begin
                size_accum_nxt = {size_accum_nxt[COUNT_WIDTH-5:0], hex.value};
              end
            end
          end
        end
        PH_SKIP: begin
          if (item.end_of_buffer) begin
            error_state_nxt = ERR_BAD;
          end else if (hex_overflow_nxt) begin
            error_state_nxt = ERR_LARGE;
          end else if (size_accum_nxt == '0) begin
            error_state_nxt = ERR_BAD;
          end else if (size_ext > budget_ext) begin
            error_state_nxt = ERR_LARGE;
          end else begin
            budget_left_nxt = budget_diff[BUDGET_W-1:0];
            data_left_nxt   = size_accum_nxt;
            phase_nxt       = PH_DATA;
          end
        end
        PH_DATA: begin
          valid         = 1'b1;
          data_left_nxt = data_dec;
          if (data_dec == '0) begin
            phase_nxt = PH_TCR;
          end
        end
        PH_TCR: begin
          if (item.data_byte == CH_CR) begin
            phase_nxt = PH_TLF;
          end else begin
            error_state_nxt = ERR_BAD;
          end
        end
        PH_TLF: begin
          if (item.data_byte == CH_LF) begin
            phase_nxt           = PH_SIZE;
            size_accum_nxt      = '0;
            line_length_nxt     = 2'd0;
            first_char_zero_nxt = 1'b0;
            hex_stopped_nxt     = 1'b0;
            hex_overflow_nxt    = 1'b0;
          end else begin
            error_state_nxt = ERR_BAD;
          end
        end
        default: begin
          phase_nxt = PH_SIZE;
        end
      endcase

      if (item.end_of_buffer && !done_flag_nxt && error_state_nxt == ERR_NONE &&
          (phase_nxt != PH_SIZE || line_length_nxt != 2'd0)) begin
        error_state_nxt = ERR_BAD;
      end
    end

    if (item.end_of_buffer) begin
      budget_left_nxt = max_body_bytes_r;
    end

    result.body_byte  = valid ? item.data_byte : 8'd0;
    result.body_valid = valid;
    result.body_done  = done_flag_nxt;
    result.error_code = error_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_bytes_r  <= BUDGET_W'(16384);
      phase_r           <= PH_SIZE;
      size_accum_r      <= '0;
      line_length_r     <= 2'd0;
      first_char_zero_r <= 1'b0;
      hex_stopped_r     <= 1'b0;
      hex_overflow_r    <= 1'b0;
      budget_left_r     <= BUDGET_W'(16384);
      data_left_r       <= '0;
      done_flag_r       <= 1'b0;
      error_state_r     <= ERR_NONE;
    end else begin
      if (cfg_wr_en) begin
        max_body_bytes_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r           <= phase_nxt;
        size_accum_r      <= size_accum_nxt;
        line_length_r     <= line_length_nxt;
        first_char_zero_r <= first_char_zero_nxt;
        hex_stopped_r     <= hex_stopped_nxt;
        hex_overflow_r    <= hex_overflow_nxt;
        budget_left_r     <= budget_left_nxt;
        data_left_r       <= data_left_nxt;
        done_flag_r       <= done_flag_nxt;
        error_state_r     <= error_state_nxt;
      end
    end
  end

  a_done_excl_error: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_flag_r && error_state_r != ERR_NONE))
    else $error("done and error both set");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (data_left_r != '0))
    else $error("data phase with zero bytes left");

  a_valid_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.body_valid) |->
      (phase_r == PH_DATA && !item.start_of_body && !done_flag_r &&
       error_state_r == ERR_NONE))
    else $error("body byte passed outside data phase");

  a_line_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (line_length_r == 2'd2 && advance && phase_r == PH_SIZE &&
     !item.start_of_body) |=> (line_length_r == 2'd2 || phase_r != PH_SIZE))
    else $error("line length left saturation inside a size line");

endmodule

`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
// Top level: input transaction register, output transaction register and the
// decoder core between them. Depends on hcbd_pkg and hcbd_core.
//
//   Channel  Ports                    Contents
//   in       in_tvalid/in_tready      tdata: data_byte; tuser: start_of_body;
//                                     tlast: end_of_buffer
//   out      out_tvalid/out_tready    tdata: body_byte; tuser: body_valid,
//                                     body_done, error_code[1:0]
//   cfg      cfg_wr_en/cfg_wr_data    max_body_bytes, write only
//
// One byte per cycle sustained while out_tready is high. A byte goes from the
// input register through the combinational decode to the output register, so
// the core state loop sets the rate.
// Reset loads max_body_bytes = 16384 and clears decoding state; no clear pass.
// A stall on out_tready holds the output; one more transaction is held at the input.
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,    // [7:0] data_byte
  input  wire logic                in_tuser,    // [0] start_of_body
  input  wire logic                in_tlast,    // end_of_buffer
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata,   // [7:0] body_byte
  output logic [3:0]               out_tuser,   // [0] body_valid, [1] body_done,
                                                // [3:2] error_code
  input  wire logic                cfg_wr_en,
  input  wire logic [BUDGET_W-1:0] cfg_wr_data
);

  logic         s1_valid_r;
  hcbd_item_t   s1_item_r;
  logic         out_valid_r;
  hcbd_result_t out_res_r;
  hcbd_result_t core_res;
  logic         advance;
  logic         in_accept;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  hcbd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item       (s1_item_r),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.data_byte     <= in_tdata;
      s1_item_r.start_of_body <= in_tuser;
      s1_item_r.end_of_buffer <= in_tlast;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.body_byte;
  assign out_tuser  = {out_res_r.error_code, out_res_r.body_done, out_res_r.body_valid};

endmodule

`default_nettype wire

@@ verif/tb_http_chunked_body_decoder.sv @@
// Self-checking testbench for http_chunked_body_decoder: a byte-level decode predictor
// with a scoreboard, directed chunk sequences, then random bodies. Depends on hcbd_pkg.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
  import hcbd_pkg::*;

  typedef enum logic [2:0] {AT_SIZE, AT_SKIP, AT_DATA, AT_TRAIL_CR, AT_TRAIL_LF} step_t;

  typedef enum int {
    FLAW_NONE, FLAW_ZERO, FLAW_OVERFLOW, FLAW_HUGE, FLAW_TRAIL_CR, FLAW_TRAIL_LF,
    FLAW_EOB_SKIP, FLAW_EOB_INSIDE
  } flaw_t;

  class chunk_scoreboard;
    logic [31:0] max_body;
    step_t step;
    logic [31:0] size_accum, budget_left, data_left;
    logic [1:0] line_len, err;
    bit first_zero, hex_stop, hex_ovf, done;
    hcbd_result_t decoded_fifo[$];
    int fails;
    int results_seen;

    function new();
      max_body = 32'd16384;
      clear_body();
    endfunction

    function void clear_line();
      size_accum = '0;
      line_len = '0;
      first_zero = 1'b0;
      hex_stop = 1'b0;
      hex_ovf = 1'b0;
    endfunction

    function void clear_body();
      step = AT_SIZE;
      clear_line();
      budget_left = max_body;
      data_left = '0;
      done = 1'b0;
      err = ERR_NONE;
    endfunction

    function bit halted();
      return done || err != ERR_NONE;
    endfunction

    function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = c[3:0];
      if (c >= "0" && c <= "9") return 1'b1;
      if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") begin
        v = c[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Predict the decode of one accepted byte; returns 1 when the byte was not ignored.
    function bit decode_byte(input logic [7:0] b, input bit sob, input bit eob);
      hcbd_result_t r;
      logic [3:0] nib;
      bit is_hex;
      bit live;
      r = '0;
      if (sob) clear_body();
      live = !halted();
      if (live) begin
        case (step)
          AT_SIZE: begin
            if (b == CH_CR) begin
              if (line_len == 2'd1 && first_zero) done = 1'b1;
              else step = AT_SKIP;
            end else begin
              is_hex = hex_digit(b, nib);
              if (line_len == 2'd0 && b == CH_ZERO) first_zero = 1'b1;
              if (line_len < 2'd2) line_len++;
              if (!is_hex) begin
                hex_stop = 1'b1;
              end else if (!hex_stop && !hex_ovf) begin
                if (size_accum[31:28] != 4'd0) hex_ovf = 1'b1;
                else size_accum = {size_accum[27:0], nib};
              end
            end
          end
          AT_SKIP: begin
            if (eob) err = ERR_BAD;
            else if (hex_ovf) err = ERR_LARGE;
            else if (size_accum == 32'd0) err = ERR_BAD;
            else if (size_accum > budget_left) err = ERR_LARGE;
            else begin
              budget_left = budget_left - size_accum;
              data_left = size_accum;
              step = AT_DATA;
            end
          end
          AT_DATA: begin
            r.body_byte = b;
            r.body_valid = 1'b1;
            data_left = data_left - 32'd1;
            if (data_left == 32'd0) step = AT_TRAIL_CR;
          end
          AT_TRAIL_CR: begin
            if (b == CH_CR) step = AT_TRAIL_LF;
            else err = ERR_BAD;
          end
          default: begin
            if (b == CH_LF) begin
              step = AT_SIZE;
              clear_line();
            end else begin
              err = ERR_BAD;
            end
          end
        endcase
        if (eob && !halted() && (step != AT_SIZE || line_len != 2'd0)) err = ERR_BAD;
      end
      if (eob) budget_left = max_body;
      r.body_done = done;
      r.error_code = err;
      decoded_fifo.push_back(r);
      return live;
    endfunction

    task report(input string msg);
      $display("[tb] result %0d: %s", results_seen, msg);
      fails++;
    endtask

    task check_output(input logic [7:0] tdata, input logic [3:0] tuser);
      hcbd_result_t want;
      results_seen++;
      if (decoded_fifo.size() == 0) begin
        report($sformatf("unexpected transaction tdata=%02h tuser=%01h", tdata, tuser));
        return;
      end
      want = decoded_fifo.pop_front();
      if (tdata !== want.body_byte)
        report($sformatf("body_byte %02h, want %02h", tdata, want.body_byte));
      if (tuser[0] !== want.body_valid)
        report($sformatf("body_valid %b, want %b", tuser[0], want.body_valid));
      if (tuser[1] !== want.body_done)
        report($sformatf("body_done %b, want %b", tuser[1], want.body_done));
      if (tuser[3:2] !== want.error_code)
        report($sformatf("error_code %0d, want %0d", tuser[3:2], want.error_code));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [BUDGET_W-1:0] cfg_wr_data = '0;

  chunk_scoreboard sb = new();
  bit steady = 1'b0;
  bit pending_start = 1'b0;
  bit restart_needed = 1'b1;
  int live_items = 0;

  http_chunked_body_decoder #(.COUNT_WIDTH(32)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tuser);
  end

  function automatic logic [7:0] not_cr();
    logic [7:0] b = 8'($urandom());
    return (b == CH_CR) ? 8'h3B : b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_ZERO;
      3: return 8'($urandom_range(8'h41, 8'h46));
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eob);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= pending_start;
    in_tlast <= eob;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (sb.decode_byte(b, pending_start, eob)) live_items++;
    pending_start = 1'b0;
  endtask

  // Mix letter case on hex digits.
  task automatic send_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      send_byte(c, 1'b0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sb.max_body = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_chunk(input flaw_t flaw, output bit cut);
    logic [31:0] size;
    logic [7:0] b;
    string txt;
    int n_data, eob_at;
    cut = 1'b0;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    case (flaw)
      FLAW_ZERO: begin
        case ($urandom_range(0, 3))
          0: txt = "0;x";
          1: txt = "00";
          2: txt = ";";
          default: txt = "";
        endcase
      end
      FLAW_OVERFLOW: txt = $sformatf("%0h%08h", $urandom_range(1, 15), $urandom());
      FLAW_HUGE: begin
        size = $urandom() | 32'h100;
        txt = $sformatf("%0h", size);
      end
      default: begin
        txt = $sformatf("%0h", size);
        if ($urandom_range(0, 6) == 0) txt = {"0", txt};
      end
    endcase
    send_text(txt);
    if (flaw != FLAW_ZERO && $urandom_range(0, 6) == 0) begin
      send_byte(";", 1'b0);
      repeat ($urandom_range(0, 4)) send_byte(not_cr(), 1'b0);
    end
    send_byte(CH_CR, 1'b0);
    send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom()) : CH_LF, flaw == FLAW_EOB_SKIP);
    if (sb.halted()) begin
      cut = 1'b1;
      return;
    end
    n_data = (size > 64) ? $urandom_range(1, 6) : size;
    eob_at = (flaw == FLAW_EOB_INSIDE) ? $urandom_range(0, n_data - 1) : -1;
    for (int i = 0; i < n_data; i++) send_byte(8'($urandom()), i == eob_at);
    if (size > 64 || sb.halted()) begin
      cut = 1'b1;
      return;
    end
    case (flaw)
      FLAW_TRAIL_CR: send_byte(not_cr(), 1'b0);
      FLAW_TRAIL_LF: begin
        send_byte(CH_CR, 1'b0);
        b = 8'($urandom());
        send_byte((b == CH_LF) ? 8'h00 : b, 1'b0);
      end
      default: begin
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, $urandom_range(0, 2) == 0);
      end
    endcase
    cut = sb.halted();
  endtask

  task automatic send_body();
    int n_chunks, flaw_at;
    bit cut;
    pending_start = restart_needed || $urandom_range(0, 4) != 0;
    restart_needed = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(noise_byte(), $urandom_range(0, 7) == 0);
      return;
    end
    n_chunks = $urandom_range(0, 4);
    flaw_at = (n_chunks != 0 && $urandom_range(0, 99) < 30) ?
              $urandom_range(0, n_chunks - 1) : -1;
    for (int i = 0; i < n_chunks; i++) begin
      send_chunk((i == flaw_at) ? flaw_t'($urandom_range(1, 7)) : FLAW_NONE, cut);
      if (cut) begin
        restart_needed = 1'b1;
        return;
      end
    end
    if ($urandom_range(0, 6) != 0) begin
      send_byte(CH_ZERO, $urandom_range(0, 19) == 0);
      send_byte(CH_CR, $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b1);
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] limit, input int target, input bit no_gaps);
    write_limit(limit);
    steady = no_gaps;
    live_items = 0;
    while (live_items < target) send_body();
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-byte chunk with extreme data values, then the terminating line on a buffer end
    pending_start = 1'b1;
    send_byte("2", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_ZERO, 1'b0);
    send_byte(CH_CR, 1'b1);
    // zero size with two digits
    pending_start = 1'b1;
    send_byte(CH_ZERO, 1'b0);
    send_byte(CH_ZERO, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    // hex overflow
    pending_start = 1'b1;
    repeat (9) send_byte("F", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);

    run_phase(32'd16384, 220, 1'b0);
    run_phase(32'd0, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, 150, 1'b1);
    run_phase(32'd40, 250, 1'b0);
    run_phase($urandom_range(1, 2000), 250, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.decoded_fifo.size() == 0) begin
      $display("[http_chunked_body_decoder] OK");
    end else begin
      $display("[http_chunked_body_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[http_chunked_body_decoder] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hcbd_pkg.sv
hdl/hcbd_core.sv
hdl/http_chunked_body_decoder.sv
verif/tb_http_chunked_body_decoder.sv
